@@ rtl/dcs_pkg.sv @@
`timescale 1ns / 1ps
// dcs_pkg: constants, codes and payload types of the disk cost stamper
// used by every module under rtl/, depends on nothing
package dcs_pkg;

  localparam int GRID_SIZE_LOG2   = 8;
  localparam int RADIUS_FRAC_BITS = 4;
  localparam int ADDR_W           = 2 * GRID_SIZE_LOG2;
  localparam int HALF_W           = 8 - RADIUS_FRAC_BITS + 1;
  localparam int OFF_W            = HALF_W + 1;
  localparam int PX_W             = (OFF_W > 9) ? OFF_W + 1 : 10;
  localparam int SQ_W             = 2 * HALF_W;
  localparam int D2_W             = SQ_W + 1 + 2 * RADIUS_FRAC_BITS;

  localparam logic [7:0] STAMP_COST_MAX = 8'd254;

  localparam logic [1:0] REQ_STAMP = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [2:0] REG_ENABLED   = 3'd0;
  localparam logic [2:0] REG_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_WIN_MIN_X = 3'd2;
  localparam logic [2:0] REG_WIN_MIN_Y = 3'd3;
  localparam logic [2:0] REG_WIN_MAX_X = 3'd4;
  localparam logic [2:0] REG_WIN_MAX_Y = 3'd5;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [HALF_W-1:0]        half_t;
  typedef logic signed [OFF_W-1:0]  off_t;
  typedef logic signed [PX_W-1:0]   pos_t;
  typedef logic [PX_W-2:0]          upos_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [D2_W-1:0]          d2_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_STAMP,
    CMD_SKIP,
    CMD_READ,
    CMD_WRITE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RWAIT,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [7:0]  radius_q;
    logic [7:0]  cost_value;
    logic [15:0] age_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_cost;
    logic        skipped;
    logic [10:0] cells_raised;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        in_grid;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    half_t       half;
    logic [15:0] r2;
    logic [7:0]  cost;
  } cmd_t;

  typedef struct packed {
    logic [8:0] min_x;
    logic [8:0] min_y;
    logic [8:0] max_x;
    logic [8:0] max_y;
  } win_t;

endpackage

@@ rtl/dcs_front.sv @@
`timescale 1ns / 1ps
// dcs_front: configuration registers and request classification
// depends on dcs_pkg
module dcs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             push,
  output logic             full,
  input  dcs_pkg::in_item_t in_data,
  input  logic             q_full,
  input  logic             clearing,
  output logic             q_push,
  output dcs_pkg::cmd_t    q_data,
  output dcs_pkg::win_t    win
);

  logic        enabled_r, enabled_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  dcs_pkg::win_t win_r, win_nxt;
  logic        cfg_we;
  logic [2:0]  reg_idx;
  logic [8:0]  half_sum;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    enabled_nxt = enabled_r;
    timeout_nxt = timeout_r;
    win_nxt     = win_r;
    if (cfg_we) begin
      case (reg_idx)
        dcs_pkg::REG_ENABLED:   enabled_nxt     = pwdata[0];
        dcs_pkg::REG_TIMEOUT:   timeout_nxt     = pwdata[15:0];
        dcs_pkg::REG_WIN_MIN_X: win_nxt.min_x   = pwdata[8:0];
        dcs_pkg::REG_WIN_MIN_Y: win_nxt.min_y   = pwdata[8:0];
        dcs_pkg::REG_WIN_MAX_X: win_nxt.max_x   = pwdata[8:0];
        dcs_pkg::REG_WIN_MAX_Y: win_nxt.max_y   = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b1;
      timeout_r   <= 16'd3000;
      win_r.min_x <= 9'd0;
      win_r.min_y <= 9'd0;
      win_r.max_x <= 9'd256;
      win_r.max_y <= 9'd256;
    end else begin
      enabled_r <= enabled_nxt;
      timeout_r <= timeout_nxt;
      win_r     <= win_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      dcs_pkg::REG_ENABLED:   prdata = {31'd0, enabled_r};
      dcs_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_r};
      dcs_pkg::REG_WIN_MIN_X: prdata = {23'd0, win_r.min_x};
      dcs_pkg::REG_WIN_MIN_Y: prdata = {23'd0, win_r.min_y};
      dcs_pkg::REG_WIN_MAX_X: prdata = {23'd0, win_r.max_x};
      dcs_pkg::REG_WIN_MAX_Y: prdata = {23'd0, win_r.max_y};
      default:                prdata = 32'd0;
    endcase
  end

  assign win    = win_r;
  assign full   = q_full || clearing;
  assign q_push = push && !full;

  // request classification
  assign half_sum = 9'(in_data.radius_q) + 9'((1 << dcs_pkg::RADIUS_FRAC_BITS) - 1);

  always_comb begin
    q_data.cell_x  = in_data.cell_x;
    q_data.cell_y  = in_data.cell_y;
    q_data.in_grid = ((in_data.cell_x >> dcs_pkg::GRID_SIZE_LOG2) == 8'd0) &&
                     ((in_data.cell_y >> dcs_pkg::GRID_SIZE_LOG2) == 8'd0);
    q_data.half    = dcs_pkg::half_t'(half_sum >> dcs_pkg::RADIUS_FRAC_BITS);
    q_data.r2      = 16'(in_data.radius_q) * 16'(in_data.radius_q);
    q_data.cost    = in_data.cost_value;
    case (in_data.req_type)
      dcs_pkg::REQ_STAMP: begin
        if (!enabled_r || (in_data.age_ms > timeout_r)) begin
          q_data.kind = dcs_pkg::CMD_SKIP;
        end else begin
          q_data.kind = dcs_pkg::CMD_STAMP;
        end
        if (in_data.cost_value > dcs_pkg::STAMP_COST_MAX) begin
          q_data.cost = dcs_pkg::STAMP_COST_MAX;
        end
      end
      dcs_pkg::REQ_READ:  q_data.kind = dcs_pkg::CMD_READ;
      dcs_pkg::REQ_WRITE: q_data.kind = dcs_pkg::CMD_WRITE;
      default:            q_data.kind = dcs_pkg::CMD_NOP;
    endcase
  end

endmodule

@@ rtl/dcs_cmdq.sv @@
`timescale 1ns / 1ps
// dcs_cmdq: two-entry queue of classified requests between front and back
// depends on dcs_pkg
module dcs_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  dcs_pkg::cmd_t q_wdata,
  output logic          q_full,
  input  logic          q_pop,
  output logic          q_empty,
  output dcs_pkg::cmd_t q_rdata
);

  dcs_pkg::cmd_t ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_rdata = ent_r[rp_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= q_wdata;
    end
  end

endmodule

@@ rtl/dcs_back.sv @@
`timescale 1ns / 1ps
// dcs_back: cost grid memory, clearing sweep, cell walk and result register
// depends on dcs_pkg
module dcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  dcs_pkg::cmd_t      q_rdata,
  output logic               q_pop,
  input  dcs_pkg::win_t      win,
  output logic               clearing,
  output logic               empty,
  input  logic               pop,
  output dcs_pkg::out_item_t out_data
);

  logic [7:0] grid_mem [2**dcs_pkg::ADDR_W];

  dcs_pkg::back_state_t state_r, state_nxt;
  dcs_pkg::addr_t       clr_addr_r, clr_addr_nxt;
  dcs_pkg::cmd_t        cmd_r, cmd_nxt;
  dcs_pkg::off_t        dx_r, dx_nxt, dy_r, dy_nxt;
  logic                 wb_v_r, wb_v_nxt;
  dcs_pkg::addr_t       wb_addr_r, wb_addr_nxt;
  logic [10:0]          cnt_r, cnt_nxt;
  dcs_pkg::out_item_t   pend_r, pend_nxt;
  dcs_pkg::out_item_t   res_r, res_nxt;
  logic                 res_v_r, res_v_nxt;
  logic [7:0]           rd_r;

  logic                 mem_we;
  dcs_pkg::addr_t       mem_waddr, mem_raddr;
  logic [7:0]           mem_wdata;

  dcs_pkg::pos_t        px, py;
  dcs_pkg::upos_t       pxu, pyu;
  dcs_pkg::half_t       adx, ady;
  dcs_pkg::sq_t         sqx, sqy;
  dcs_pkg::d2_t         d2;
  dcs_pkg::off_t        half_s;
  dcs_pkg::addr_t       cell_addr, q_addr;
  logic                 in_grid, in_win, in_disk, hit, raise;

  // current cell of the walk
  always_comb begin
    half_s  = dcs_pkg::off_t'(cmd_r.half);
    px      = dcs_pkg::pos_t'($signed({1'b0, cmd_r.cell_x})) + dcs_pkg::pos_t'(dx_r);
    py      = dcs_pkg::pos_t'($signed({1'b0, cmd_r.cell_y})) + dcs_pkg::pos_t'(dy_r);
    pxu     = px[dcs_pkg::PX_W-2:0];
    pyu     = py[dcs_pkg::PX_W-2:0];
    adx     = dx_r[dcs_pkg::OFF_W-1] ? dcs_pkg::half_t'(-dx_r) : dcs_pkg::half_t'(dx_r);
    ady     = dy_r[dcs_pkg::OFF_W-1] ? dcs_pkg::half_t'(-dy_r) : dcs_pkg::half_t'(dy_r);
    sqx     = dcs_pkg::sq_t'(adx) * dcs_pkg::sq_t'(adx);
    sqy     = dcs_pkg::sq_t'(ady) * dcs_pkg::sq_t'(ady);
    d2      = (dcs_pkg::d2_t'(sqx) + dcs_pkg::d2_t'(sqy)) << (2 * dcs_pkg::RADIUS_FRAC_BITS);
    in_disk = (d2 <= dcs_pkg::d2_t'(cmd_r.r2));
    in_grid = !px[dcs_pkg::PX_W-1] && !py[dcs_pkg::PX_W-1] &&
              ((pxu >> dcs_pkg::GRID_SIZE_LOG2) == '0) &&
              ((pyu >> dcs_pkg::GRID_SIZE_LOG2) == '0);
    in_win  = (pxu >= dcs_pkg::upos_t'(win.min_x)) && (pxu < dcs_pkg::upos_t'(win.max_x)) &&
              (pyu >= dcs_pkg::upos_t'(win.min_y)) && (pyu < dcs_pkg::upos_t'(win.max_y));
    hit       = in_grid && in_win && in_disk;
    cell_addr = (dcs_pkg::addr_t'(pyu) << dcs_pkg::GRID_SIZE_LOG2) | dcs_pkg::addr_t'(pxu);
    q_addr    = (dcs_pkg::addr_t'(q_rdata.cell_y) << dcs_pkg::GRID_SIZE_LOG2) |
                dcs_pkg::addr_t'(q_rdata.cell_x);
    raise     = wb_v_r && (cmd_r.cost > rd_r);
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cmd_nxt      = cmd_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    wb_v_nxt     = 1'b0;
    wb_addr_nxt  = cell_addr;
    cnt_nxt      = cnt_r + 11'(raise);
    pend_nxt     = pend_r;
    res_nxt      = res_r;
    res_v_nxt    = res_v_r && !pop;
    q_pop        = 1'b0;
    mem_we       = raise;
    mem_waddr    = wb_addr_r;
    mem_wdata    = cmd_r.cost;
    mem_raddr    = cell_addr;
    clearing     = 1'b0;
    case (state_r)
      dcs_pkg::ST_CLEAR: begin
        clearing     = 1'b1;
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = 8'd0;
        clr_addr_nxt = clr_addr_r + dcs_pkg::addr_t'(1);
        if (clr_addr_r == '1) begin
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      dcs_pkg::ST_IDLE: begin
        pend_nxt = '0;
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_rdata;
          mem_raddr = q_addr;
          state_nxt = dcs_pkg::ST_DONE;
          case (q_rdata.kind)
            dcs_pkg::CMD_STAMP: begin
              dx_nxt    = -dcs_pkg::off_t'(q_rdata.half);
              dy_nxt    = -dcs_pkg::off_t'(q_rdata.half);
              cnt_nxt   = 11'd0;
              state_nxt = dcs_pkg::ST_WALK;
            end
            dcs_pkg::CMD_SKIP: pend_nxt.skipped = 1'b1;
            dcs_pkg::CMD_READ: state_nxt = dcs_pkg::ST_RWAIT;
            dcs_pkg::CMD_WRITE: begin
              mem_we    = q_rdata.in_grid;
              mem_waddr = q_addr;
              mem_wdata = q_rdata.cost;
            end
            default: ;
          endcase
        end
      end
      dcs_pkg::ST_RWAIT: begin
        pend_nxt.read_cost = cmd_r.in_grid ? rd_r : 8'd0;
        state_nxt          = dcs_pkg::ST_DONE;
      end
      dcs_pkg::ST_WALK: begin
        wb_v_nxt = hit;
        if (dx_r == half_s) begin
          dx_nxt = -half_s;
          if (dy_r == half_s) begin
            state_nxt = dcs_pkg::ST_DRAIN;
          end else begin
            dy_nxt = dy_r + dcs_pkg::off_t'(1);
          end
        end else begin
          dx_nxt = dx_r + dcs_pkg::off_t'(1);
        end
      end
      dcs_pkg::ST_DRAIN: begin
        pend_nxt.cells_raised = cnt_nxt;
        state_nxt             = dcs_pkg::ST_DONE;
      end
      dcs_pkg::ST_DONE: begin
        if (!res_v_r || pop) begin
          res_nxt   = pend_r;
          res_v_nxt = 1'b1;
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dcs_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      wb_v_r     <= 1'b0;
      res_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      wb_v_r     <= wb_v_nxt;
      res_v_r    <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    wb_addr_r <= wb_addr_nxt;
    cnt_r     <= cnt_nxt;
    pend_r    <= pend_nxt;
    res_r     <= res_nxt;
  end

  // grid memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= grid_mem[mem_raddr];
  end

  assign empty    = !res_v_r;
  assign out_data = res_r;

endmodule

@@ rtl/disk_cost_stamper_top.sv @@
`timescale 1ns / 1ps
// disk_cost_stamper_top: disk cost stamper, front, request queue and back
// depends on dcs_pkg, dcs_front, dcs_cmdq, dcs_back
//
//   channel   handshake                  payload
//   input     push / full                in_data  (dcs_pkg::in_item_t)
//   result    empty / pop                out_data (dcs_pkg::out_item_t)
//   config    psel penable pwrite pready paddr pwdata prdata
//
// a stamp walks the (2*ceil(radius)+1)^2 cells of its square, one cell per cycle
// through the grid memory port, then the drain and done states; a read takes the
// read wait and done states, a write, a skipped stamp or an unused request type only the done state
// after reset all 65536 grid cells are swept to zero with full held high
// the front keeps taking requests into a two-entry queue while a result waits, until the queue is full
module disk_cost_stamper_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  dcs_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output dcs_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic          q_push, q_full, q_pop, q_empty, clearing;
  dcs_pkg::cmd_t q_wdata, q_rdata;
  dcs_pkg::win_t win;

  dcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .win      (win)
  );

  dcs_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_rdata (q_rdata)
  );

  dcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .win      (win),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
